@@ design/so3e_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SO(3) exponential map package
// Shared widths, latencies, trig constants and series divisors.
// ----------------------------------------------------------------------------
package so3e_pkg;

	// threshold register width
	localparam int THR_W = 31;

	// square root: one result bit per stage
	localparam int SQRT_STG = 32;
	// axis divider: one setup stage plus one quotient bit per stage
	localparam int DIV_STG = 32;
	// phase, range reduction and series evaluation
	localparam int SC_STG = 29;
	localparam int SC_PAD = DIV_STG - SC_STG;

	// series terms and reciprocal scale for constant division
	localparam int TERMS    = 7;
	localparam int RECIP_SH = 34;

	// 2^64 / (2 pi) and pi * 2^62, split in halves
	localparam logic [31:0] TURN_HI = 32'h28BE60DB;
	localparam logic [31:0] TURN_LO = 32'h9391054A;
	localparam logic [31:0] PI_HI   = 32'hC90FDAA2;
	localparam logic [31:0] PI_LO   = 32'h2168C235;

	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

	typedef logic [7:0] divc_t;
	localparam divc_t SIN_DIV [TERMS] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};
	localparam divc_t COS_DIV [TERMS] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} quad_t;

endpackage

@@ design/so3_exponential_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SO(3) exponential map
// Rotation vector (Q7.24) to saturated rotation matrix (Q1.30).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one request: rot_x, rot_y, rot_z.
//   Output channel out_valid/out_ready carries the nine entries m00..m22.
//   Config channel cfg_valid/cfg_ready writes small_angle_threshold; write
//   it only while no request is in flight. cfg_ready is always high.
//   Throughput: one request per cycle while the skid register is empty. The
//   pipeline has 73 stages (squares, a 32-stage bit-serial square root, a
//   32-stage divider for the unit axis running beside the sine/cosine
//   series, then the matrix assembly), the first of them loaded at the
//   accepting edge, followed by an output register that drives out_valid.
//   A skid register behind the output register lets one more result land
//   while the receiver stalls; the whole pipeline holds once it is full and
//   in_ready drops, so nothing is lost or repeated.
//   Reset (arst_n low) empties the pipeline and sets the threshold to 1.
// ----------------------------------------------------------------------------
module so3_exponential_map (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [31:0]                rot_x,
	input  logic signed [31:0]                rot_y,
	input  logic signed [31:0]                rot_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [31:0]                m00,
	output logic signed [31:0]                m01,
	output logic signed [31:0]                m02,
	output logic signed [31:0]                m10,
	output logic signed [31:0]                m11,
	output logic signed [31:0]                m12,
	output logic signed [31:0]                m20,
	output logic signed [31:0]                m21,
	output logic signed [31:0]                m22,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [so3e_pkg::THR_W-1:0]        cfg_data
);
	import so3e_pkg::*;

	localparam int NSTG = 3 + SQRT_STG + 1 + DIV_STG + 5;
	localparam int PA [6] = '{0, 1, 2, 0, 0, 1};
	localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

	function automatic logic signed [31:0] sat30(input logic signed [47:0] a);
		if (a > 48'(ONE_Q30))
			return ONE_Q30;
		else if (a < -48'(ONE_Q30))
			return -ONE_Q30;
		else
			return 32'(a);
	endfunction

	logic [THR_W-1:0] thr_q;
	logic             en;
	logic [NSTG-1:0]  vld_q;
	logic             push;

	logic signed [31:0] v_s1 [3];
	logic signed [63:0] sq_s2 [3];
	logic signed [31:0] v_s2 [3];
	logic [63:0]        n_s3;
	logic signed [31:0] v_s3 [3];

	logic [33:0]        rt_rem_s  [SQRT_STG];
	logic [31:0]        rt_root_s [SQRT_STG];
	logic [63:0]        rt_n_s    [SQRT_STG];
	logic signed [31:0] rt_v_s    [SQRT_STG][3];

	logic [31:0]        len_s36;
	logic               tay_s36;
	logic signed [31:0] v_s36 [3];

	logic [31:0]        mag [3];
	logic [30:0]        quo [3];
	logic signed [31:0] sc_sn, sc_cs;
	logic signed [31:0] sn_pad_s [SC_PAD];
	logic signed [31:0] cs_pad_s [SC_PAD];
	logic signed [31:0] side_v_s [DIV_STG][3];
	logic               side_tay_s [DIV_STG];

	logic signed [31:0] u_n [3];
	logic signed [31:0] u_s69 [3];
	logic signed [31:0] sn_s69;
	logic signed [32:0] omc_s69;
	logic signed [31:0] v_s69 [3];
	logic               tay_s69;

	logic signed [63:0] uu_s70 [6];
	logic signed [63:0] vv_s70 [6];
	logic signed [63:0] su_s70 [3];
	logic signed [32:0] omc_s70;
	logic signed [31:0] v_s70 [3];
	logic               tay_s70;

	logic signed [33:0] p_n   [3][3];
	logic signed [34:0] sk_n  [3][3];
	logic signed [47:0] tm_n  [3][3];
	logic signed [33:0] p_s71 [3][3];
	logic signed [34:0] sk_s71 [3][3];
	logic signed [47:0] tm_s71 [3][3];
	logic signed [32:0] omc_s71;
	logic               tay_s71;

	logic signed [66:0] op_s72 [3][3];
	logic signed [34:0] sk_s72 [3][3];
	logic signed [47:0] tm_s72 [3][3];
	logic               tay_s72;

	logic signed [31:0] res_n   [3][3];
	logic signed [31:0] res_s73 [3][3];

	logic               out_valid_q, skid_v_q;
	logic signed [31:0] out_q  [3][3];
	logic signed [31:0] skid_q [3][3];

	// threshold register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(1);
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// pipeline advance and valid tracking
	assign en       = !skid_v_q;
	assign in_ready = en;
	assign push     = vld_q[NSTG-1] && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], in_valid};
		end
	end

	// capture, square, sum
	always_ff @(posedge clk) begin
		if (en) begin
			v_s1[0] <= rot_x;
			v_s1[1] <= rot_y;
			v_s1[2] <= rot_z;
			for (int c = 0; c < 3; c++) begin
				sq_s2[c] <= v_s1[c] * v_s1[c];
				v_s2[c]  <= v_s1[c];
				v_s3[c]  <= v_s2[c];
			end
			n_s3 <= $unsigned(sq_s2[0]) + $unsigned(sq_s2[1]) + $unsigned(sq_s2[2]);
		end
	end

	// square root, one root bit per stage
	for (genvar j = 0; j < SQRT_STG; j++) begin : g_sqrt
		logic [33:0]        rem_prev;
		logic [31:0]        root_prev;
		logic [63:0]        n_prev;
		logic signed [31:0] v_prev [3];
		logic [35:0]        cur, trial, diff;
		logic               take;

		if (j == 0) begin : g_first
			assign rem_prev  = '0;
			assign root_prev = '0;
			assign n_prev    = n_s3;
			assign v_prev    = v_s3;
		end else begin : g_next
			assign rem_prev  = rt_rem_s[j-1];
			assign root_prev = rt_root_s[j-1];
			assign n_prev    = rt_n_s[j-1];
			assign v_prev    = rt_v_s[j-1];
		end

		always_comb begin
			cur   = {rem_prev, n_prev[63-2*j -: 2]};
			trial = {2'b00, root_prev, 2'b01};
			take  = cur >= trial;
			diff  = cur - trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem_s[j]  <= take ? diff[33:0] : cur[33:0];
				rt_root_s[j] <= {root_prev[30:0], take};
				rt_n_s[j]    <= n_prev;
				rt_v_s[j]    <= v_prev;
			end
		end
	end

	// pick the path
	always_ff @(posedge clk) begin
		if (en) begin
			len_s36 <= rt_root_s[SQRT_STG-1];
			tay_s36 <= (rt_root_s[SQRT_STG-1] == 32'd0) ||
			           (rt_root_s[SQRT_STG-1] < {1'b0, thr_q});
			v_s36   <= rt_v_s[SQRT_STG-1];
		end
	end

	// unit axis dividers and the trig unit run side by side
	for (genvar c = 0; c < 3; c++) begin : g_axis
		assign mag[c] = v_s36[c][31] ? (~v_s36[c] + 32'd1) : v_s36[c];

		so3e_div u_div (
			.clk (clk),
			.en  (en),
			.mag (mag[c]),
			.len (len_s36),
			.quo (quo[c])
		);
	end

	so3e_sincos u_sincos (
		.clk (clk),
		.en  (en),
		.len (len_s36),
		.sn  (sc_sn),
		.cs  (sc_cs)
	);

	// align trig results and side data with the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			sn_pad_s[0]   <= sc_sn;
			cs_pad_s[0]   <= sc_cs;
			for (int i = 1; i < SC_PAD; i++) begin
				sn_pad_s[i] <= sn_pad_s[i-1];
				cs_pad_s[i] <= cs_pad_s[i-1];
			end
			side_v_s[0]   <= v_s36;
			side_tay_s[0] <= tay_s36;
			for (int i = 1; i < DIV_STG; i++) begin
				side_v_s[i]   <= side_v_s[i-1];
				side_tay_s[i] <= side_tay_s[i-1];
			end
		end
	end

	// signed, clamped axis
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (quo[c] > 31'h4000_0000)
				u_n[c] = ONE_Q30;
			else
				u_n[c] = $signed({1'b0, quo[c]});
			if (side_v_s[DIV_STG-1][c][31])
				u_n[c] = -u_n[c];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s69   <= u_n;
			sn_s69  <= sn_pad_s[SC_PAD-1];
			omc_s69 <= 33'(ONE_Q30) - 33'(cs_pad_s[SC_PAD-1]);
			v_s69   <= side_v_s[DIV_STG-1];
			tay_s69 <= side_tay_s[DIV_STG-1];
		end
	end

	// pair products of the axis and of the raw vector, sine times axis
	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 6; p++) begin
				uu_s70[p] <= u_s69[PA[p]] * u_s69[PB[p]];
				vv_s70[p] <= v_s69[PA[p]] * v_s69[PB[p]];
			end
			for (int c = 0; c < 3; c++) begin
				su_s70[c] <= sn_s69 * u_s69[c];
			end
			omc_s70 <= omc_s69;
			v_s70   <= v_s69;
			tay_s70 <= tay_s69;
		end
	end

	// K^2 entries, sine terms and the whole small-angle matrix
	always_comb begin
		logic signed [65:0] w;
		logic signed [47:0] kv;
		int                 c, pid;
		logic               neg;

		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				c   = 3 - i - j;
				pid = i + j + 2;
				neg = (j == (i + 1) % 3);
				if (i == j) begin
					w          = 66'(uu_s70[(i+1)%3]) + 66'(uu_s70[(i+2)%3])
					           + 66'sd536870912;
					w          = w >>> 30;
					p_n[i][j]  = -34'(w);
					sk_n[i][j] = '0;
					w          = 66'(vv_s70[(i+1)%3]) + 66'(vv_s70[(i+2)%3])
					           + 66'sd262144;
					w          = w >>> 19;
					tm_n[i][j] = 48'(ONE_Q30) - 48'(w);
				end else begin
					w          = 66'(uu_s70[pid]) + 66'sd536870912;
					p_n[i][j]  = 34'(w >>> 30);
					w          = neg ? -66'(su_s70[c]) : 66'(su_s70[c]);
					w          = (w + 66'sd536870912) >>> 30;
					sk_n[i][j] = 35'(w);
					w          = 66'(vv_s70[pid]) + 66'sd262144;
					w          = w >>> 19;
					kv         = neg ? -48'(v_s70[c]) : 48'(v_s70[c]);
					tm_n[i][j] = (kv <<< 6) + 48'(w);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s71   <= p_n;
			sk_s71  <= sk_n;
			tm_s71  <= tm_n;
			omc_s71 <= omc_s70;
			tay_s71 <= tay_s70;
		end
	end

	// scale K^2 by one minus cosine
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					op_s72[i][j] <= 67'(omc_s71) * 67'(p_s71[i][j]);
				end
			end
			sk_s72  <= sk_s71;
			tm_s72  <= tm_s71;
			tay_s72 <= tay_s71;
		end
	end

	// assemble, select path, saturate
	always_comb begin
		logic signed [66:0] r;
		logic signed [47:0] rod;

		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				r   = (op_s72[i][j] + 67'sd536870912) >>> 30;
				rod = ((i == j) ? 48'(ONE_Q30) : 48'sd0) + 48'(sk_s72[i][j]) + 48'(r);
				res_n[i][j] = sat30(tay_s72 ? tm_s72[i][j] : rod);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s73 <= res_n;
		end
	end

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_v_q    <= 1'b0;
		end else if (skid_v_q) begin
			if (!out_valid_q || out_ready) begin
				out_valid_q <= 1'b1;
				skid_v_q    <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !out_ready)
				skid_v_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (!out_valid_q || out_ready)
				out_q <= skid_q;
		end else if (push) begin
			if (out_valid_q && !out_ready)
				skid_q <= res_s73;
			else
				out_q <= res_s73;
		end
	end

	assign out_valid = out_valid_q;
	assign m00 = out_q[0][0];
	assign m01 = out_q[0][1];
	assign m02 = out_q[0][2];
	assign m10 = out_q[1][0];
	assign m11 = out_q[1][1];
	assign m12 = out_q[1][2];
	assign m20 = out_q[2][0];
	assign m21 = out_q[2][1];
	assign m22 = out_q[2][2];

	// checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_valid_q)
		else $error("skid holds a request while the output register is empty");

	a_skid_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !out_ready) |=> skid_v_q)
		else $error("skid request dropped during a stall");

	a_diag_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (m00 >= -ONE_Q30 && m00 <= ONE_Q30 &&
		                 m11 >= -ONE_Q30 && m11 <= ONE_Q30 &&
		                 m22 >= -ONE_Q30 && m22 <= ONE_Q30))
		else $error("diagonal entry outside the saturation range");

endmodule

@@ design/so3e_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis component divider
// Pipelined restoring division: round(mag * 2^30 / len), one bit a stage.
// ----------------------------------------------------------------------------
module so3e_div (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] mag,
	input  logic [31:0] len,
	output logic [30:0] quo
);
	import so3e_pkg::*;

	localparam int QW = DIV_STG - 1;

	logic [61:0]   num;
	logic [31:0]   rem_s [DIV_STG];
	logic [QW-1:0] low_s [DIV_STG];
	logic [QW-1:0] quo_s [DIV_STG];
	logic [31:0]   len_s [DIV_STG];

	// form the rounded numerator
	assign num = {mag, 30'd0} + {31'd0, len[31:1]};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {1'b0, num[61:31]};
			low_s[0] <= num[30:0];
			quo_s[0] <= '0;
			len_s[0] <= len;
		end
	end

	// one quotient bit per stage
	for (genvar i = 1; i < DIV_STG; i++) begin : g_stage
		logic [32:0] trial;
		logic        take;
		logic [32:0] diff;

		always_comb begin
			trial = {rem_s[i-1], low_s[i-1][QW-1]};
			take  = trial >= {1'b0, len_s[i-1]};
			diff  = trial - {1'b0, len_s[i-1]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? diff[31:0] : trial[31:0];
				low_s[i] <= {low_s[i-1][QW-2:0], 1'b0};
				quo_s[i] <= {quo_s[i-1][QW-2:0], take};
				len_s[i] <= len_s[i-1];
			end
		end
	end

	assign quo = quo_s[DIV_STG-1];

endmodule

@@ design/so3e_sincos.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle to sine and cosine
// Turns reduction, quarter-wave mapping and a pipelined Taylor series.
// ----------------------------------------------------------------------------
module so3e_sincos (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        len,
	output logic signed [31:0] sn,
	output logic signed [31:0] cs
);
	import so3e_pkg::*;

	logic [63:0] mh_s1, ml_s1;
	logic [63:0] acc_p2;
	logic [31:0] phase_s2;
	logic [63:0] ph_s3, pl_s3;
	quad_t       quad_s3;
	logic [63:0] acc_p4;
	logic [31:0] x_s4;
	quad_t       quad_s4;
	logic [63:0] xx_s5;
	logic [31:0] x_s5;
	quad_t       quad_s5;
	logic [64:0] x2_p6;

	// series state at term boundaries
	logic [32:0]        tm_x2 [TERMS+1];
	logic [31:0]        tm_ts [TERMS+1];
	logic [31:0]        tm_tc [TERMS+1];
	logic signed [35:0] tm_as [TERMS+1];
	logic signed [35:0] tm_ac [TERMS+1];
	quad_t              tm_quad [TERMS+1];

	logic signed [35:0] rs_f1, rc_f1;
	logic signed [31:0] s0_s28, c0_s28;
	quad_t              quad_s28;
	logic signed [31:0] sn_s29, cs_s29;

	// angle times turns per radian
	always_ff @(posedge clk) begin
		if (en) begin
			mh_s1 <= {32'd0, len} * {32'd0, TURN_HI};
			ml_s1 <= {32'd0, len} * {32'd0, TURN_LO};
		end
	end

	assign acc_p2 = mh_s1 + {32'd0, ml_s1[63:32]} + 64'h0080_0000;

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s2 <= acc_p2[55:24];
		end
	end

	// quarter turn back to radians
	always_ff @(posedge clk) begin
		if (en) begin
			ph_s3   <= {34'd0, phase_s2[29:0]} * {32'd0, PI_HI};
			pl_s3   <= {34'd0, phase_s2[29:0]} * {32'd0, PI_LO};
			quad_s3 <= quad_t'(phase_s2[31:30]);
		end
	end

	assign acc_p4 = ph_s3 + {32'd0, pl_s3[63:32]} + 64'h2000_0000;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4    <= acc_p4[61:30];
			quad_s4 <= quad_s3;
		end
	end

	// square of the reduced angle
	always_ff @(posedge clk) begin
		if (en) begin
			xx_s5   <= {32'd0, x_s4} * {32'd0, x_s4};
			x_s5    <= x_s4;
			quad_s5 <= quad_s4;
		end
	end

	assign x2_p6 = {1'b0, xx_s5} + 65'h4000_0000;

	always_ff @(posedge clk) begin
		if (en) begin
			tm_x2[0]   <= x2_p6[63:31];
			tm_ts[0]   <= x_s5;
			tm_tc[0]   <= 32'h8000_0000;
			tm_as[0]   <= $signed({4'd0, x_s5});
			tm_ac[0]   <= 36'sh0_8000_0000;
			tm_quad[0] <= quad_s5;
		end
	end

	// three stages per term: multiply, reciprocal multiply, correct and add
	for (genvar k = 0; k < TERMS; k++) begin : g_term
		localparam logic [RECIP_SH:0] MS = (35'd1 << RECIP_SH) / SIN_DIV[k];
		localparam logic [RECIP_SH:0] MC = (35'd1 << RECIP_SH) / COS_DIV[k];
		localparam bit SUB = (k % 2) == 0;

		logic [64:0]        ps_sa, pc_sa;
		logic [32:0]        x2_sa, x2_sb;
		logic signed [35:0] as_sa, ac_sa, as_sb, ac_sb;
		quad_t              quad_sa, quad_sb;
		logic [33:0]        ns_sb, nc_sb;
		logic [68:0]        es_sb, ec_sb;
		logic [34:0]        qs, qc;
		logic [43:0]        chk_s, chk_c;
		logic [31:0]        ts_n, tc_n;

		always_ff @(posedge clk) begin
			if (en) begin
				ps_sa   <= 65'(tm_ts[k]) * 65'(tm_x2[k]);
				pc_sa   <= 65'(tm_tc[k]) * 65'(tm_x2[k]);
				x2_sa   <= tm_x2[k];
				as_sa   <= tm_as[k];
				ac_sa   <= tm_ac[k];
				quad_sa <= tm_quad[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ns_sb   <= ps_sa[64:31];
				nc_sb   <= pc_sa[64:31];
				es_sb   <= 69'(ps_sa[64:31]) * 69'(MS);
				ec_sb   <= 69'(pc_sa[64:31]) * 69'(MC);
				x2_sb   <= x2_sa;
				as_sb   <= as_sa;
				ac_sb   <= ac_sa;
				quad_sb <= quad_sa;
			end
		end

		// the reciprocal estimate is at most one short
		always_comb begin
			qs    = es_sb[RECIP_SH +: 35];
			qc    = ec_sb[RECIP_SH +: 35];
			chk_s = 44'(qs + 35'd1) * 44'(SIN_DIV[k]);
			chk_c = 44'(qc + 35'd1) * 44'(COS_DIV[k]);
			ts_n  = (chk_s <= 44'(ns_sb)) ? 32'(qs + 35'd1) : qs[31:0];
			tc_n  = (chk_c <= 44'(nc_sb)) ? 32'(qc + 35'd1) : qc[31:0];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tm_ts[k+1]   <= ts_n;
				tm_tc[k+1]   <= tc_n;
				tm_x2[k+1]   <= x2_sb;
				tm_quad[k+1] <= quad_sb;
				if (SUB) begin
					tm_as[k+1] <= as_sb - $signed({4'd0, ts_n});
					tm_ac[k+1] <= ac_sb - $signed({4'd0, tc_n});
				end else begin
					tm_as[k+1] <= as_sb + $signed({4'd0, ts_n});
					tm_ac[k+1] <= ac_sb + $signed({4'd0, tc_n});
				end
			end
		end
	end

	// drop to Q1.30 and clamp to the quarter-wave range
	assign rs_f1 = (tm_as[TERMS] + 36'sd1) >>> 1;
	assign rc_f1 = (tm_ac[TERMS] + 36'sd1) >>> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			if (rs_f1 < 36'sd0)
				s0_s28 <= '0;
			else if (rs_f1 > 36'(ONE_Q30))
				s0_s28 <= ONE_Q30;
			else
				s0_s28 <= 32'(rs_f1);
			if (rc_f1 < 36'sd0)
				c0_s28 <= '0;
			else if (rc_f1 > 36'(ONE_Q30))
				c0_s28 <= ONE_Q30;
			else
				c0_s28 <= 32'(rc_f1);
			quad_s28 <= tm_quad[TERMS];
		end
	end

	// rotate into the quadrant
	always_ff @(posedge clk) begin
		if (en) begin
			unique case (quad_s28)
				QUAD_0: begin
					sn_s29 <= s0_s28;
					cs_s29 <= c0_s28;
				end
				QUAD_1: begin
					sn_s29 <= c0_s28;
					cs_s29 <= -s0_s28;
				end
				QUAD_2: begin
					sn_s29 <= -s0_s28;
					cs_s29 <= -c0_s28;
				end
				QUAD_3: begin
					sn_s29 <= -c0_s28;
					cs_s29 <= s0_s28;
				end
			endcase
		end
	end

	assign sn = sn_s29;
	assign cs = cs_s29;

endmodule

@@ tb/so3e_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SO(3) exponential map checker
// Watches the config, request and result channels, computes the expected
// rotation matrix for every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module so3e_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] rot_x,
	input  logic signed [31:0] rot_y,
	input  logic signed [31:0] rot_z,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] m00,
	input  logic signed [31:0] m01,
	input  logic signed [31:0] m02,
	input  logic signed [31:0] m10,
	input  logic signed [31:0] m11,
	input  logic signed [31:0] m12,
	input  logic signed [31:0] m20,
	input  logic signed [31:0] m21,
	input  logic signed [31:0] m22,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [30:0]        cfg_data,
	output int                 fail_count,
	output int                 pending,
	output int                 result_count
);
	import so3e_pkg::*;

	typedef struct packed {
		logic signed [31:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	} rot_mat_t;

	rot_mat_t     expected_mats[$];
	logic [30:0]  taylor_limit;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// quarter-turn sine/cosine series, Q.31 in, Q1.30 out
	function automatic void quarter_sincos(longint unsigned x, output longint sn,
			output longint cs);
		longint unsigned x2, ts, tc;
		longint as_, ac;
		x2 = (x * x + (64'd1 << 30)) >> 31;
		ts = x;
		tc = 64'd1 << 31;
		as_ = longint'(x);
		ac = longint'(64'd1 << 31);
		for (int k = 1; k <= 7; k++) begin
			ts = ((ts * x2) >> 31) / longint'((2 * k) * (2 * k + 1));
			tc = ((tc * x2) >> 31) / longint'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				as_ -= longint'(ts);
				ac -= longint'(tc);
			end else begin
				as_ += longint'(ts);
				ac += longint'(tc);
			end
		end
		sn = sat(round_shift(as_, 1), 0, 64'sd1 << 30);
		cs = sat(round_shift(ac, 1), 0, 64'sd1 << 30);
	endfunction

	function automatic rot_mat_t rotation_of(logic signed [31:0] vx, logic signed [31:0] vy,
			logic signed [31:0] vz, logic [30:0] limit);
		longint v[3], u[3], kk[3][3], m[3][3];
		longint unsigned sq[3], len, acc, ph, r, x, mag, q;
		longint s0, c0, sn, cs, omc, p, one;
		quad_t quad;
		rot_mat_t res;
		one = 64'sd1 << 30;
		v[0] = vx; v[1] = vy; v[2] = vz;
		for (int i = 0; i < 3; i++) sq[i] = v[i] * v[i];
		len = int_sqrt(sq[0] + sq[1] + sq[2]);
		if (len == 0 || len < limit) begin
			kk = '{'{0, -v[2], v[1]}, '{v[2], 0, -v[0]}, '{-v[1], v[0], 0}};
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					if (i == j)
						p = -longint'((sq[(i + 1) % 3] + sq[(i + 2) % 3] + (64'd1 << 18)) >> 19);
					else
						p = round_shift(v[i] * v[j], 19);
					m[i][j] = (i == j ? one : 0) + kk[i][j] * 64 + p;
				end
		end else begin
			for (int i = 0; i < 3; i++) begin
				mag = v[i] < 0 ? -v[i] : v[i];
				q = ((mag << 30) + (len >> 1)) / len;
				if (q > 64'd1 << 30) q = 64'd1 << 30;
				u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
			end
			acc = len * TURN_HI + ((len * TURN_LO) >> 32);
			ph = ((acc + (64'd1 << 23)) >> 24) & 64'hFFFF_FFFF;
			quad = quad_t'(ph[31:30]);
			r = ph & 64'h3FFF_FFFF;
			acc = r * PI_HI + ((r * PI_LO) >> 32);
			x = (acc + (64'd1 << 29)) >> 30;
			quarter_sincos(x, s0, c0);
			case (quad)
				QUAD_0: begin sn = s0; cs = c0; end
				QUAD_1: begin sn = c0; cs = -s0; end
				QUAD_2: begin sn = -s0; cs = -c0; end
				default: begin sn = -c0; cs = s0; end
			endcase
			omc = one - cs;
			kk = '{'{0, -u[2], u[1]}, '{u[2], 0, -u[0]}, '{-u[1], u[0], 0}};
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					if (i == j)
						p = -round_shift(u[(i + 1) % 3] * u[(i + 1) % 3]
							+ u[(i + 2) % 3] * u[(i + 2) % 3], 30);
					else
						p = round_shift(u[i] * u[j], 30);
					m[i][j] = (i == j ? one : 0) + round_shift(sn * kk[i][j], 30)
						+ round_shift(omc * p, 30);
				end
		end
		res.e00 = 32'(sat(m[0][0], -one, one)); res.e01 = 32'(sat(m[0][1], -one, one));
		res.e02 = 32'(sat(m[0][2], -one, one)); res.e10 = 32'(sat(m[1][0], -one, one));
		res.e11 = 32'(sat(m[1][1], -one, one)); res.e12 = 32'(sat(m[1][2], -one, one));
		res.e20 = 32'(sat(m[2][0], -one, one)); res.e21 = 32'(sat(m[2][1], -one, one));
		res.e22 = 32'(sat(m[2][2], -one, one));
		return res;
	endfunction

	// predict on request, compare on result
	always @(posedge clk or negedge arst_n) begin
		rot_mat_t want, got;
		if (!arst_n) begin
			taylor_limit = 31'd1;
			fail_count = 0;
			result_count = 0;
			pending = 0;
			expected_mats.delete();
		end else begin
			if (in_valid && in_ready)
				expected_mats.push_back(rotation_of(rot_x, rot_y, rot_z, taylor_limit));
			if (cfg_valid && cfg_ready)
				taylor_limit = cfg_data;
			if (out_valid && out_ready) begin
				got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
				result_count++;
				if (expected_mats.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %0d: %h", result_count, got);
				end else begin
					want = expected_mats.pop_front();
					if (want !== got) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch result %0d: expected %h actual %h",
								result_count, want, got);
					end
				end
			end
			pending = expected_mats.size();
		end
	end
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SO(3) exponential map testbench
// Drives directed and random rotation vectors under several threshold
// settings and flow-control mixes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_ready;
	logic signed [31:0] rot_x = '0, rot_y = '0, rot_z = '0;
	logic out_valid, out_ready = 1'b0;
	logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [30:0] cfg_data = '0;
	int fail_count, pending, result_count;
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit hold_off = 1'b0;
	int idle_cycles = 0;
	int sent = 0;

	localparam int LATENCY = 80;
	localparam int WATCHDOG = 5000;

	always #5 clk = ~clk;

	so3_exponential_map dut (.*);

	so3e_checker checker_i (.*);

	// receiver: random stalls, plus a long hold-off when asked
	always @(posedge clk) begin
		out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on accepted traffic
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog: no traffic for %0d cycles", WATCHDOG);
			$display("status: fail");
			$finish;
		end
	end

	// offer one request; valid stays up into the next request unless idling
	task automatic send_request(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		rot_x <= x; rot_y <= y; rot_z <= z;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	// drop the request line and wait until every result is back
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_threshold(logic [30:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] rand_component(int shape);
		case (shape)
			0: return $urandom;
			1: return $signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
			2: return $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
			default: return $signed($urandom_range(32'h6000_0000)) - 32'sh3000_0000;
		endcase
	endfunction

	task automatic random_batch(int count);
		int shape;
		for (int n = 0; n < count; n++) begin
			shape = $urandom_range(3);
			send_request(rand_component(shape), rand_component(shape), rand_component(shape));
		end
	endtask

	initial begin
		logic signed [31:0] edges[7];
		edges = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1, -1, 32'sh0100_0000, 32'sh0324_3F6A};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero length, extremes, axis-aligned angles across quadrants
		foreach (edges[i]) send_request(edges[i], 0, 0);
		send_request(0, edges[0], edges[1]);
		send_request(edges[0], edges[0], edges[0]);
		send_request(edges[1], edges[1], edges[1]);
		send_request(32'sh0100_0000, -32'sh0100_0000, 32'sh0080_0000);
		send_request(0, 0, 32'sh0648_7ED5);
		send_request(0, 32'sh04B6_5F1F, 0);
		send_request(32'sh0001_0000, 0, 32'sh0002_0000);
		write_threshold(31'd0);
		send_request(0, 0, 0);
		send_request(1, 1, 1);
		send_request(32'sh0100_0000, 0, 0);
		write_threshold(31'h7FFF_FFFF);
		send_request(32'sh0100_0000, 0, 0);
		send_request(edges[0], edges[1], edges[0]);
		send_request(32'sh0000_4000, -32'sh0000_2000, 32'sh0000_1000);

		// random phases with varying thresholds and flow-control mixes
		write_threshold(31'h0001_0000);
		random_batch(400);
		send_idle_pct = 68;
		write_threshold(31'($urandom_range(32'h0200_0000)));
		random_batch(300);
		send_idle_pct = 0; recv_stall_pct = 68;
		write_threshold(31'd1);
		random_batch(300);
		send_idle_pct = 17; recv_stall_pct = 17;
		write_threshold(31'h0080_0000);
		random_batch(300);

		// long receiver hold-off while the sender keeps offering
		send_idle_pct = 0; recv_stall_pct = 0;
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			random_batch(150);
		join
		// sender pauses until every result is back
		drain();
		write_threshold(31'd0);
		random_batch(230);

		drain();
		$display("covered %0d requests, %0d results, thresholds 0..max, four flow mixes",
			sent, result_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
